@@ rtl/lab2rgb_pkg.sv @@
// lab2rgb_pkg: fixed-point constants and rounding helpers for the Lab to linear sRGB pipe.
// Standalone; used by lab_to_linear_srgb_d50 through scoped names.
package lab2rgb_pkg;

  typedef logic signed [27:0] q24c_t;   // Q24 / Q32 constants, all fit in 28 signed bits

  // Reciprocals, Q32
  localparam q24c_t RCP_116 = 28'sd37025581;
  localparam q24c_t RCP_500 = 28'sd8589935;
  localparam q24c_t RCP_200 = 28'sd21474836;

  localparam logic [15:0] SIXTEEN_Q8 = 16'd4096;

  // Companding constants, Q24
  localparam q24c_t DELTA_Q24  = 28'sd3471148;
  localparam q24c_t FOUR29_Q24 = 28'sd2314099;
  localparam q24c_t SLOPE_Q24  = 28'sd2154506;

  // D50 white point, Q24 (Y is unity)
  localparam q24c_t WHITE_X_Q24 = 28'sd16176592;
  localparam q24c_t WHITE_Z_Q24 = 28'sd13839525;

  // XYZ to linear sRGB, row major, Q24
  localparam q24c_t MAT_Q24 [9] = '{
     28'sd52577381, -28'sd27126522,  -28'sd8231147,
    -28'sd16421009,  28'sd32147520,    28'sd561265,
      28'sd1207042,  -28'sd3841838,  28'sd23576060
  };

  localparam int unsigned NUM_STAGES = 11;

  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  // Shift right by s with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] neg;
    half = 64'sd1 <<< (s - 1);
    neg  = $signed({63'd0, v[63]});
    return (v + half - neg) >>> s;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[17:0];
  endfunction

endpackage

@@ rtl/lab_to_linear_srgb_d50.sv @@
// lab_to_linear_srgb_d50: CIE Lab (D50) to linear sRGB, fully pipelined.
// Depends on lab2rgb_pkg for constants and rounding helpers.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  lab     | lab_valid / lab_stall | l_star[15u], a_star[16s], b_star[16s]
//  rgb     | rgb_valid / rgb_stall | red_lin, green_lin, blue_lin [18s]
//
// One item per clock while rgb is not stalled; the pipe depth is set by the multiplier chain
// (reciprocals, square, cube, white point, matrix), each product registered.
// Synchronous active-high reset clears the valid bits only.
// A stall on rgb, while a result is waiting in the output register, freezes the whole
// pipe and is passed back as lab_stall.
module lab_to_linear_srgb_d50 (
  input  logic               clk,
  input  logic               rst,
  input  logic               lab_valid,
  output logic               lab_stall,
  input  logic        [14:0] l_star,
  input  logic signed [15:0] a_star,
  input  logic signed [15:0] b_star,
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output logic signed [17:0] red_lin,
  output logic signed [17:0] green_lin,
  output logic signed [17:0] blue_lin
);

  localparam int unsigned NS = lab2rgb_pkg::NUM_STAGES;

  logic          adv;
  logic [NS-1:0] vld;

  // stage 1: reciprocal products
  logic signed [44:0] pl1;
  logic signed [43:0] pa1, pb1;
  // stage 2: fx, fy, fz (lane 0 x, 1 y, 2 z), Q24
  logic signed [26:0] t2 [3];
  // stage 3: raw square and linear-segment products
  logic signed [53:0] psq3 [3];
  logic signed [55:0] plin3 [3];
  logic signed [26:0] t3 [3];
  logic               cub3 [3];
  // stage 4
  logic signed [27:0] sq4 [3];
  logic signed [23:0] lin4 [3];
  logic signed [26:0] t4 [3];
  logic               cub4 [3];
  // stage 5
  logic signed [54:0] pcube5 [3];
  logic signed [23:0] lin5 [3];
  logic               cub5 [3];
  // stage 6: companded values
  logic signed [28:0] e6 [3];
  // stage 7: white point products
  logic signed [56:0] pwx7, pwz7;
  logic signed [28:0] ey7;
  // stage 8: X, Y, Z
  logic signed [28:0] xyz8 [3];
  // stage 9: matrix products
  logic signed [56:0] pm9 [9];
  // stage 10: row sums, Q48
  logic signed [58:0] acc10 [3];

  // combinational helpers for stage 2
  logic        [15:0] lsum;
  logic signed [26:0] fy_c, ra_c, rb_c;

  assign lsum = {1'b0, l_star} + lab2rgb_pkg::SIXTEEN_Q8;
  assign fy_c = 27'(lab2rgb_pkg::rnd_shift(64'(pl1), 16));
  assign ra_c = 27'(lab2rgb_pkg::rnd_shift(64'(pa1), 16));
  assign rb_c = 27'(lab2rgb_pkg::rnd_shift(64'(pb1), 16));

  assign adv       = !rgb_valid || !rgb_stall;
  assign lab_stall = !adv;
  assign rgb_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], lab_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      pl1 <= $signed({1'b0, lsum}) * lab2rgb_pkg::RCP_116;
      pa1 <= a_star * lab2rgb_pkg::RCP_500;
      pb1 <= b_star * lab2rgb_pkg::RCP_200;

      // stage 2
      t2[0] <= fy_c + ra_c;
      t2[1] <= fy_c;
      t2[2] <= fy_c - rb_c;

      for (int c = 0; c < 3; c++) begin
        // stage 3
        psq3[c]  <= t2[c] * t2[c];
        plin3[c] <= (28'(t2[c]) - lab2rgb_pkg::FOUR29_Q24) * lab2rgb_pkg::SLOPE_Q24;
        t3[c]    <= t2[c];
        cub3[c]  <= 28'(t2[c]) > lab2rgb_pkg::DELTA_Q24;
        // stage 4
        sq4[c]   <= 28'(lab2rgb_pkg::rnd_shift(64'(psq3[c]), 24));
        lin4[c]  <= 24'(lab2rgb_pkg::rnd_shift(64'(plin3[c]), 24));
        t4[c]    <= t3[c];
        cub4[c]  <= cub3[c];
        // stage 5
        pcube5[c] <= sq4[c] * t4[c];
        lin5[c]   <= lin4[c];
        cub5[c]   <= cub4[c];
        // stage 6: cube above 6/29, linear segment at or below
        if (cub5[c]) begin
          e6[c] <= 29'(lab2rgb_pkg::rnd_shift(64'(pcube5[c]), 24));
        end else begin
          e6[c] <= 29'(lin5[c]);
        end
      end

      // stage 7
      pwx7 <= e6[0] * lab2rgb_pkg::WHITE_X_Q24;
      pwz7 <= e6[2] * lab2rgb_pkg::WHITE_Z_Q24;
      ey7  <= e6[1];

      // stage 8
      xyz8[0] <= 29'(lab2rgb_pkg::rnd_shift(64'(pwx7), 24));
      xyz8[1] <= ey7;
      xyz8[2] <= 29'(lab2rgb_pkg::rnd_shift(64'(pwz7), 24));

      // stage 9
      for (int k = 0; k < 9; k++) begin
        pm9[k] <= lab2rgb_pkg::MAT_Q24[k] * xyz8[k % 3];
      end

      // stage 10
      for (int r = 0; r < 3; r++) begin
        acc10[r] <= 59'(pm9[3*r]) + 59'(pm9[3*r+1]) + 59'(pm9[3*r+2]);
      end

      // stage 11: Q48 to Q14, saturate
      red_lin   <= lab2rgb_pkg::sat18(lab2rgb_pkg::rnd_shift(64'(acc10[0]), 34));
      green_lin <= lab2rgb_pkg::sat18(lab2rgb_pkg::rnd_shift(64'(acc10[1]), 34));
      blue_lin  <= lab2rgb_pkg::sat18(lab2rgb_pkg::rnd_shift(64'(acc10[2]), 34));
    end
  end

`ifndef SYNTHESIS
  // input is held back only while a finished item waits at the output
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    lab_stall |-> (rgb_valid && rgb_stall))
    else $error("lab_stall raised without a waiting result");

  // a waiting result keeps the row sums behind it frozen
  a_sums_hold: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && rgb_stall && vld[NS-2]) |=>
      ($stable(acc10[0]) && $stable(acc10[1]) && $stable(acc10[2])))
    else $error("pipe moved under a stalled output");

  // fy never falls below 4/29, so Y is never negative
  a_y_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> !xyz8[1][28])
    else $error("negative Y from the companding stage");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !rgb_valid)
    else $error("result valid after reset");
`endif

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for lab_to_linear_srgb_d50 (Lab D50 to linear sRGB, Q14 out).
// Needs only the RTL; carries its own fixed-point model of the colour conversion.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic signed [17:0] red;
    logic signed [17:0] green;
    logic signed [17:0] blue;
  } rgb_t;

  typedef struct packed {
    logic        [14:0] l;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               known;
    rgb_t               want;
  } lab_row_t;

  // Q32 reciprocals, Q24 companding and white point
  localparam longint K_RCP116   = 37025581;
  localparam longint K_RCP500   = 8589935;
  localparam longint K_RCP200   = 21474836;
  localparam longint K_SIXTEEN  = 4096;
  localparam longint K_KNEE     = 3471148;
  localparam longint K_FOUR29   = 2314099;
  localparam longint K_SLOPE    = 2154506;
  localparam longint K_WHITE_X  = 16176592;
  localparam longint K_WHITE_Z  = 13839525;
  // XYZ (D50) to linear sRGB, Q24
  localparam longint M_RX =  52577381, M_RY = -27126522, M_RZ = -8231147;
  localparam longint M_GX = -16421009, M_GY =  32147520, M_GZ =   561265;
  localparam longint M_BX =   1207042, M_BY =  -3841838, M_BZ = 23576060;
  localparam longint SAT_HI = 131071;
  localparam longint SAT_LO = -131072;

  localparam int ITEMS_PER_PHASE = 700;
  localparam int MAX_PRINTED     = 40;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               lab_valid = 1'b0;
  logic               lab_stall;
  logic        [14:0] l_star    = '0;
  logic signed [15:0] a_star    = '0;
  logic signed [15:0] b_star    = '0;
  logic               rgb_valid;
  logic               rgb_stall = 1'b0;
  logic signed [17:0] red_lin;
  logic signed [17:0] green_lin;
  logic signed [17:0] blue_lin;

  rgb_t pending_rgb [$];
  int   n_err     = 0;
  int   n_lab     = 0;
  int   n_rgb     = 0;
  int   hold_left = 0;
  int   src_idle  = 0;
  int   snk_idle  = 0;

  lab_to_linear_srgb_d50 dut (
    .clk       (clk),
    .rst       (rst),
    .lab_valid (lab_valid),
    .lab_stall (lab_stall),
    .l_star    (l_star),
    .a_star    (a_star),
    .b_star    (b_star),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .red_lin   (red_lin),
    .green_lin (green_lin),
    .blue_lin  (blue_lin)
  );

  always #10 clk = ~clk;

  initial begin
    #4000000;
    $display("Timeout: %0d items in, %0d results out", n_lab, n_rgb);
    $display("Some tests failed");
    $finish;
  end

  // right shift with rounding to nearest, ties away from zero
  function automatic longint rnd_away(input longint v, input int s);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -q : q;
  endfunction

  // inverse Lab companding: cube above the knee, linear segment at or below it
  function automatic longint lab_expand_q24(input longint t);
    longint sq;
    if (t > K_KNEE) begin
      sq = rnd_away(t * t, 24);
      return rnd_away(sq * t, 24);
    end
    return rnd_away((t - K_FOUR29) * K_SLOPE, 24);
  endfunction

  function automatic logic signed [17:0] clamp18(input longint v);
    if (v > SAT_HI) return 18'sh1FFFF;
    if (v < SAT_LO) return 18'sh20000;
    return 18'(v);
  endfunction

  function automatic rgb_t convert_pixel(input logic [14:0] l,
                                         input logic signed [15:0] a,
                                         input logic signed [15:0] b);
    longint fy, fx, fz, xw, yw, zw;
    rgb_t   p;
    fy = rnd_away((longint'(l) + K_SIXTEEN) * K_RCP116, 16);
    fx = fy + rnd_away(longint'(a) * K_RCP500, 16);
    fz = fy - rnd_away(longint'(b) * K_RCP200, 16);
    xw = rnd_away(lab_expand_q24(fx) * K_WHITE_X, 24);
    yw = lab_expand_q24(fy);
    zw = rnd_away(lab_expand_q24(fz) * K_WHITE_Z, 24);
    p.red   = clamp18(rnd_away(M_RX * xw + M_RY * yw + M_RZ * zw, 34));
    p.green = clamp18(rnd_away(M_GX * xw + M_GY * yw + M_GZ * zw, 34));
    p.blue  = clamp18(rnd_away(M_BX * xw + M_BY * yw + M_BZ * zw, 34));
    return p;
  endfunction

  function automatic lab_row_t row_of(input logic [14:0] l,
                                      input logic signed [15:0] a,
                                      input logic signed [15:0] b);
    lab_row_t r;
    r.l = l;
    r.a = a;
    r.b = b;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (n_err < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    n_err++;
  endtask

  // offer one item and hold it until taken, then maybe go idle for a while
  task automatic push_lab(input logic [14:0] l, input logic signed [15:0] a,
                          input logic signed [15:0] b, input rgb_t want);
    int gap;
    lab_valid <= 1'b1;
    l_star    <= l;
    a_star    <= a;
    b_star    <= b;
    @(posedge clk);
    while (lab_stall) @(posedge clk);
    pending_rgb.push_back(want);
    n_lab++;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < src_idle) gap++;
    if (gap > 0) begin
      lab_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output side: check each result, drive stall, and two long holds to back up the pipe
  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (rst) begin
      rgb_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (rgb_valid && !rgb_stall) begin
        if (pending_rgb.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                  red_lin, green_lin, blue_lin));
        end else begin
          exp_rgb = pending_rgb.pop_front();
          if (red_lin !== exp_rgb.red || green_lin !== exp_rgb.green ||
              blue_lin !== exp_rgb.blue)
            note_mismatch($sformatf("item %0d rgb got %0d/%0d/%0d want %0d/%0d/%0d",
                                    n_rgb, red_lin, green_lin, blue_lin,
                                    exp_rgb.red, exp_rgb.green, exp_rgb.blue));
        end
        n_rgb <= n_rgb + 1;
      end
      if (rgb_valid && !rgb_stall && (n_rgb == 299 || n_rgb == 1499)) begin
        hold_left <= 64;
        rgb_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rgb_stall <= 1'b1;
      end else begin
        rgb_stall <= ($urandom_range(0, 99) < snk_idle);
      end
    end
  end

  initial begin : stim
    lab_row_t    dir_tab [$];
    lab_row_t    row;
    rgb_t        want;
    logic [14:0] l;
    logic signed [15:0] a, b;
    int          i, ph, sel, ri;

    // black: fy lands exactly on 4/29, so all three channels are zero
    row = row_of(15'd0, 16'sd0, 16'sd0);
    row.known = 1'b1;
    row.want = '0;
    dir_tab.push_back(row);
    dir_tab.push_back(row_of(15'd25600, 16'sd0, 16'sd0));       // L = 100
    dir_tab.push_back(row_of(15'h7FFF, 16'sd0, 16'sd0));        // L code above 100
    dir_tab.push_back(row_of(15'd2048, 16'sd0, 16'sd0));        // fx=fy=fz on the 6/29 knee
    dir_tab.push_back(row_of(15'd2049, 16'sd0, 16'sd0));        // just above the knee
    dir_tab.push_back(row_of(15'd2047, 16'sd0, 16'sd0));        // just below the knee
    dir_tab.push_back(row_of(15'd0, 16'sh8000, 16'sh8000));
    dir_tab.push_back(row_of(15'd0, 16'sh7FFF, 16'sh7FFF));
    dir_tab.push_back(row_of(15'd0, 16'sh7FFF, 16'sh8000));
    dir_tab.push_back(row_of(15'h7FFF, 16'sh7FFF, 16'sh8000));  // saturation candidates
    dir_tab.push_back(row_of(15'h7FFF, 16'sh8000, 16'sh7FFF));
    dir_tab.push_back(row_of(15'h7FFF, 16'sh8000, 16'sh8000));
    dir_tab.push_back(row_of(15'h7FFF, 16'sh7FFF, 16'sh7FFF));
    dir_tab.push_back(row_of(15'd25600, 16'sh7FFF, 16'sd0));
    dir_tab.push_back(row_of(15'd25600, 16'sh8000, 16'sd0));
    dir_tab.push_back(row_of(15'd25600, 16'sd0, 16'sh7FFF));
    dir_tab.push_back(row_of(15'd25600, 16'sd0, 16'sh8000));
    dir_tab.push_back(row_of(15'd12800, 16'sd0, 16'sd0));
    dir_tab.push_back(row_of(15'h5555, 16'sh5555, 16'shAAAA));
    dir_tab.push_back(row_of(15'h2AAA, 16'shAAAA, 16'sh5555));
    dir_tab.push_back(row_of(15'd1, 16'sd1, 16'shFFFF));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    src_idle = 15;
    snk_idle <= 48;

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      want = row.known ? row.want : convert_pixel(row.l, row.a, row.b);
      push_lab(row.l, row.a, row.b, want);
    end

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle = 48;
        snk_idle <= 15;
      end else if (ph == 2) begin
        src_idle = 0;
        snk_idle <= 0;
      end
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6 || sel == 8) begin
          // mostly nominal colours; sel 8 pushes L past 100
          l = (sel == 8) ? 15'($urandom_range(25601, 32767)) : 15'($urandom_range(0, 25600));
          ri = int'($urandom_range(0, 51200)) - 25600;
          a = 16'(ri);
          ri = int'($urandom_range(0, 51200)) - 25600;
          b = 16'(ri);
        end else if (sel == 7) begin
          // hover around the companding knee
          l = 15'($urandom_range(1900, 2200));
          ri = int'($urandom_range(0, 1024)) - 512;
          a = 16'(ri);
          ri = int'($urandom_range(0, 1024)) - 512;
          b = 16'(ri);
        end else begin
          l = (sel == 6) ? 15'($urandom_range(0, 32767)) : 15'($urandom_range(0, 3000));
          a = 16'($urandom_range(0, 65535));
          b = 16'($urandom_range(0, 65535));
        end
        push_lab(l, a, b, convert_pixel(l, a, b));
      end
    end

    lab_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    $display("Converted %0d Lab items (%0d directed: knee, black, white, L codes over 100,",
             n_lab, dir_tab.size());
    $display("  axis extremes) and compared %0d results under swapped, absent and long stalls",
             n_rgb);
    if (n_err == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ lab_to_linear_srgb_d50.f @@
rtl/lab2rgb_pkg.sv
rtl/lab_to_linear_srgb_d50.sv
tb/tb.sv
